FILE: design/tlbl_pkg.sv
// shared types and constants for the translation buffer
`timescale 1ns / 1ps
package tlbl_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CFG_W       = 6;
  localparam int CAP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int RM_W        = 6;
  localparam int PID_W       = 16;
  localparam int PAGE_W      = 16;
  localparam int FRAME_W     = 16;
  localparam int STAMP_W     = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_FILL   = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef struct packed {
    op_e                opcode;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] fill_frame;
  } tlbl_in_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               replaced;
    logic [RM_W-1:0]    removed_count;
  } tlbl_out_t;

  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_COMMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

FILE: design/tlbl_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module tlbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/tlbl_ctrl.sv
// sequencer for the entry scan and the update step
`timescale 1ns / 1ps
module tlbl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output tlbl_pkg::cmd_t cmd_o,
  input  tlbl_pkg::sts_t sts_i
);
  import tlbl_pkg::*;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q == IDX_W'(MAX_ENTRIES - 1)) begin
          state_d = ST_TAIL;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_TAIL: state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.rd_addr = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN:   cmd_o.rd_en  = 1'b1;
      ST_TAIL:   cmd_o        = '0;
      ST_COMMIT: cmd_o.commit = sts_i.out_free;
      default:   cmd_o        = '0;
    endcase
  end

endmodule

FILE: design/tlbl_datapath.sv
// entry store, scan accumulators, update and result register
`timescale 1ns / 1ps
module tlbl_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tlbl_pkg::tlbl_in_t     in_data_i,
  input  logic                   cfg_we_i,
  input  logic [tlbl_pkg::CFG_W-1:0] cfg_data_i,
  input  tlbl_pkg::cmd_t         cmd_i,
  output tlbl_pkg::sts_t         sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output tlbl_pkg::tlbl_out_t    out_data_o
);
  import tlbl_pkg::*;

  logic [CFG_W-1:0]       cfg_q;
  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [STAMP_W-1:0]     counter_q, counter_d;
  tlbl_in_t               req_q;

  // eval stage lines up with the registered ram read
  logic             ev_valid_q;
  logic [IDX_W-1:0] ev_idx_q;
  entry_t           rd_entry;

  // scan accumulators
  logic               match_q, match_d;
  logic [IDX_W-1:0]   match_idx_q, match_idx_d;
  logic [FRAME_W-1:0] match_frame_q, match_frame_d;
  logic [CNT_W-1:0]   vcnt_q, vcnt_d;
  logic               free_q, free_d;
  logic [IDX_W-1:0]   free_idx_q, free_idx_d;
  logic               old_q, old_d;
  logic [IDX_W-1:0]   old_idx_q, old_idx_d;
  logic [STAMP_W-1:0] old_age_q, old_age_d;
  logic [RM_W-1:0]    rm_q, rm_d;

  logic               out_valid_q;
  tlbl_out_t          out_q, out_d;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic [CAP_W-1:0]   cap;
  logic               ent_v;
  logic [STAMP_W-1:0] age;

  tlbl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rd_entry)
  );

  assign cap = (CAP_W'(cfg_q) > CAP_W'(MAX_ENTRIES)) ? CAP_W'(MAX_ENTRIES) : CAP_W'(cfg_q);
  assign ent_v = ev_valid_q & valid_q[ev_idx_q];
  assign age   = counter_q - rd_entry.stamp;

  // scan evaluation
  always_comb begin
    match_d       = match_q;
    match_idx_d   = match_idx_q;
    match_frame_d = match_frame_q;
    vcnt_d        = vcnt_q;
    free_d        = free_q;
    free_idx_d    = free_idx_q;
    old_d         = old_q;
    old_idx_d     = old_idx_q;
    old_age_d     = old_age_q;
    rm_d          = rm_q;
    if (cmd_i.load) begin
      match_d = 1'b0;
      vcnt_d  = '0;
      free_d  = 1'b0;
      old_d   = 1'b0;
      rm_d    = '0;
    end else if (ev_valid_q) begin
      if (ent_v) begin
        vcnt_d = vcnt_q + 1'b1;
        if (!match_q && rd_entry.pid == req_q.pid && rd_entry.page == req_q.page) begin
          match_d       = 1'b1;
          match_idx_d   = ev_idx_q;
          match_frame_d = rd_entry.frame;
        end
        if (!old_q || age > old_age_q) begin
          old_d     = 1'b1;
          old_idx_d = ev_idx_q;
          old_age_d = age;
        end
        if (req_q.opcode == OP_FLUSH && rd_entry.pid == req_q.pid) begin
          rm_d = rm_q + 1'b1;
        end
      end else if (!free_q) begin
        free_d     = 1'b1;
        free_idx_d = ev_idx_q;
      end
    end
  end

  // update step and result
  always_comb begin
    valid_d   = valid_q;
    counter_d = counter_q;
    ram_we    = 1'b0;
    ram_waddr = match_idx_q;
    ram_wdata = '{pid: req_q.pid, page: req_q.page, frame: req_q.fill_frame,
                  stamp: counter_q};
    out_d     = '0;
    // flush clears entries as the scan passes them
    if (ent_v && req_q.opcode == OP_FLUSH && rd_entry.pid == req_q.pid) begin
      valid_d[ev_idx_q] = 1'b0;
    end
    if (cmd_i.commit) begin
      unique case (req_q.opcode)
        OP_LOOKUP: begin
          if (cap != '0 && match_q) begin
            ram_we          = 1'b1;
            ram_wdata.frame = match_frame_q;
            counter_d       = counter_q + 1'b1;
            out_d.hit       = 1'b1;
            out_d.frame     = match_frame_q;
          end
        end
        OP_FILL: begin
          if (cap != '0) begin
            ram_we    = 1'b1;
            counter_d = counter_q + 1'b1;
            priority if (match_q) begin
              ram_waddr = match_idx_q;
            end else if (CAP_W'(vcnt_q) < cap && free_q) begin
              ram_waddr = free_idx_q;
            end else begin
              // evict the oldest stamp, slot zero when nothing is valid
              ram_waddr      = old_q ? old_idx_q : '0;
              out_d.replaced = 1'b1;
            end
            valid_d[ram_waddr] = 1'b1;
          end
        end
        OP_FLUSH: out_d.removed_count = rm_q;
        OP_NOP:   out_d = '0;
        default:  out_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      valid_q     <= '0;
      counter_q   <= '0;
      ev_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      valid_q    <= valid_d;
      counter_q  <= counter_d;
      ev_valid_q <= cmd_i.rd_en;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q      <= cmd_i.rd_addr;
    match_q       <= match_d;
    match_idx_q   <= match_idx_d;
    match_frame_q <= match_frame_d;
    vcnt_q        <= vcnt_d;
    free_q        <= free_d;
    free_idx_q    <= free_idx_d;
    old_q         <= old_d;
    old_idx_q     <= old_idx_d;
    old_age_q     <= old_age_d;
    rm_q          <= rm_d;
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

FILE: design/tlb_lru_lookup_fill_flush_unit.sv
// top level of the fully associative translation buffer with lru replacement
//
//   channel | signals                              | direction | beat
//   --------+--------------------------------------+-----------+---------------------
//   request | in_valid_i, in_ready_o, in_data_i    | in        | op, pid, page, frame
//   result  | out_valid_o, out_ready_i, out_data_o | out       | hit, frame, evict, count
//   config  | cfg_we_i, cfg_data_i                 | in        | entries_in_use
//
// each request passes through an accept step, a scan that streams all 32
// entries out of the single read port of the entry ram, a step to fold in
// the last read and an update step that writes the chosen entry
// reset empties the buffer, zeroes the use counter and sets entries_in_use to 32
// a result waits in the output register; a new request is taken meanwhile and
// its update cycle holds until the waiting result beat has gone
`timescale 1ns / 1ps
module tlb_lru_lookup_fill_flush_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  tlbl_pkg::tlbl_in_t         in_data_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output tlbl_pkg::tlbl_out_t        out_data_o,
  // configuration write
  input  logic                       cfg_we_i,
  input  logic [tlbl_pkg::CFG_W-1:0] cfg_data_i
);
  import tlbl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: walks the entry index and fires the update step
  tlbl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // entry store, match / free / oldest search and result register
  tlbl_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for the lru translation buffer: directed table, then random phases
`timescale 1ns / 1ps
module tb_top;
  import tlbl_pkg::*;

  // clock, reset and block ports
  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  tlbl_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  tlbl_out_t out_data_o;
  logic      cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  tlb_lru_lookup_fill_flush_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // shadow copy of the buffer: entries, use stamps and the usable count
  logic               shadow_valid [MAX_ENTRIES];
  logic [PID_W-1:0]   shadow_pid   [MAX_ENTRIES];
  logic [PAGE_W-1:0]  shadow_page  [MAX_ENTRIES];
  logic [FRAME_W-1:0] shadow_frame [MAX_ENTRIES];
  logic [STAMP_W-1:0] shadow_stamp [MAX_ENTRIES];
  logic [STAMP_W-1:0] use_clock = '0;
  logic [CFG_W-1:0]   usable_cfg = CFG_RESET;

  // translations still owed by the block, oldest first
  tlbl_out_t owed_answers [$];

  int errors     = 0;
  int reqs_taken = 0;
  int answers_ok = 0;
  int hit_total  = 0;
  int evict_total = 0;
  int widest_flush = 0;

  // random traffic shaping for the current phase
  bit                 calm = 1'b0;
  logic [PID_W-1:0]   pid_pool [4];
  int                 pid_cnt   = 1;
  logic [PAGE_W-1:0]  page_base = '0;
  int                 page_span = 1;
  int                 fill_pct  = 40;
  int                 flush_pct = 5;
  tlbl_in_t           last_req  = '0;
  tlbl_out_t          last_ans  = '0;

  initial begin
    for (int i = 0; i < MAX_ENTRIES; i++) shadow_valid[i] = 1'b0;
  end

  // mostly short gaps, now and then a long one, none in calm phases
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int find_translation(logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page);
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (shadow_valid[i] && shadow_pid[i] == pid && shadow_page[i] == page) return i;
    return -1;
  endfunction

  // applies one request to the shadow buffer and returns the translation it answers
  function automatic tlbl_out_t apply_tlb_op(tlbl_in_t req);
    tlbl_out_t          ans;
    int                 cap;
    int                 k;
    int                 used;
    int                 free_slot;
    int                 gone;
    logic [STAMP_W-1:0] age;
    logic [STAMP_W-1:0] oldest_age;
    ans = '0;
    cap = (int'(usable_cfg) > MAX_ENTRIES) ? MAX_ENTRIES : int'(usable_cfg);
    case (req.opcode)
      OP_LOOKUP: begin
        if (cap != 0) begin
          k = find_translation(req.pid, req.page);
          if (k >= 0) begin
            ans.hit      = 1'b1;
            ans.frame    = shadow_frame[k];
            shadow_stamp[k] = use_clock;
            use_clock++;
          end
        end
      end
      OP_FILL: begin
        if (cap != 0) begin
          k = find_translation(req.pid, req.page);
          if (k < 0) begin
            used      = 0;
            free_slot = -1;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
              if (shadow_valid[i]) used++;
              else if (free_slot < 0) free_slot = i;
            end
            if (used < cap && free_slot >= 0) begin
              k = free_slot;
            end else begin
              // victim: largest age modulo the stamp width, lowest index on ties
              oldest_age = '0;
              for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (shadow_valid[i]) begin
                  age = use_clock - shadow_stamp[i];
                  if (k < 0 || age > oldest_age) begin
                    k          = i;
                    oldest_age = age;
                  end
                end
              end
              if (k < 0) k = 0;
              ans.replaced = 1'b1;
            end
          end
          shadow_valid[k] = 1'b1;
          shadow_pid[k]   = req.pid;
          shadow_page[k]  = req.page;
          shadow_frame[k] = req.fill_frame;
          shadow_stamp[k] = use_clock;
          use_clock++;
        end
      end
      OP_FLUSH: begin
        gone = 0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (shadow_valid[i] && shadow_pid[i] == req.pid) begin
            shadow_valid[i] = 1'b0;
            gone++;
          end
        end
        ans.removed_count = RM_W'(gone);
      end
      default: ;
    endcase
    return ans;
  endfunction

  // drives one request beat; valid stays up until the handshake
  task automatic send_req(tlbl_in_t req, bit typed, tlbl_out_t typed_ans);
    int        gap;
    tlbl_out_t ans;
    gap = pick_gap();
    if (gap == 0) begin
      in_valid_i <= 1'b1;
      in_data_i  <= req;
    end else begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      in_valid_i <= 1'b1;
      in_data_i  <= req;
    end
    do @(posedge clk_i); while (!in_ready_o);
    ans = apply_tlb_op(req);
    owed_answers.push_back(typed ? typed_ans : ans);
    reqs_taken++;
    if (ans.hit) hit_total++;
    if (ans.replaced) evict_total++;
    if (int'(ans.removed_count) > widest_flush) widest_flush = int'(ans.removed_count);
    last_req = req;
    last_ans = ans;
  endtask

  // waits for every owed result, then writes entries_in_use
  task automatic write_usable(logic [CFG_W-1:0] value);
    in_valid_i <= 1'b0;
    while (owed_answers.size() != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    usable_cfg = value;
  endtask

  // random request: fill after a miss, phase-shaped traffic, some pure noise
  function automatic tlbl_in_t make_req();
    tlbl_in_t req;
    int       r;
    req.opcode     = OP_LOOKUP;
    req.pid        = pid_pool[$urandom_range(0, pid_cnt - 1)];
    req.page       = page_base + PAGE_W'($urandom_range(0, page_span - 1));
    req.fill_frame = FRAME_W'($urandom);
    r = $urandom_range(0, 99);
    if (last_req.opcode == OP_LOOKUP && !last_ans.hit && usable_cfg != 0 && r < 60) begin
      // page walk done, install the translation that just missed
      req            = last_req;
      req.opcode     = OP_FILL;
      req.fill_frame = FRAME_W'($urandom);
    end else if ($urandom_range(0, 99) < 8) begin
      req.opcode     = op_e'($urandom_range(0, 3));
      req.pid        = PID_W'($urandom);
      req.page       = PAGE_W'($urandom);
      req.fill_frame = FRAME_W'($urandom);
    end else begin
      r = $urandom_range(0, 99);
      if (r < flush_pct) req.opcode = OP_FLUSH;
      else if (r < flush_pct + 2) req.opcode = OP_NOP;
      else if (r < flush_pct + 2 + fill_pct) req.opcode = OP_FILL;
      else req.opcode = OP_LOOKUP;
    end
    return req;
  endfunction

  // directed table: optional register write first, then one request
  typedef struct packed {
    logic             wr;
    logic [CFG_W-1:0] cfgv;
    op_e              op;
    logic [15:0]      pid;
    logic [15:0]      page;
    logic [15:0]      frame;
    logic             typed;
    tlbl_out_t        ans;
  } step_t;

  step_t directed_plan [25] = '{
    // empty after reset, extremes of pid and page, refill, nop, flush
    '{1'b0, 6'd0,  OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b1, '{1'b0, 16'h0000, 1'b0, 6'd0}},
    '{1'b0, 6'd0,  OP_FILL,   16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{1'b0, 16'h0000, 1'b0, 6'd0}},
    '{1'b0, 6'd0,  OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, '{1'b1, 16'hFFFF, 1'b0, 6'd0}},
    '{1'b0, 6'd0,  OP_FILL,   16'h0000, 16'h0000, 16'h0000, 1'b1, '{1'b0, 16'h0000, 1'b0, 6'd0}},
    '{1'b0, 6'd0,  OP_LOOKUP, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, '{1'b1, 16'h0000, 1'b0, 6'd0}},
    '{1'b0, 6'd0,  OP_FILL,   16'hFFFF, 16'hFFFF, 16'h1234, 1'b1, '{1'b0, 16'h0000, 1'b0, 6'd0}},
    '{1'b0, 6'd0,  OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, '{1'b1, 16'h1234, 1'b0, 6'd0}},
    '{1'b0, 6'd0,  OP_NOP,    16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{1'b0, 16'h0000, 1'b0, 6'd0}},
    '{1'b0, 6'd0,  OP_FLUSH,  16'hFFFF, 16'h0000, 16'h0000, 1'b1, '{1'b0, 16'h0000, 1'b0, 6'd1}},
    '{1'b0, 6'd0,  OP_FLUSH,  16'hFFFF, 16'h0000, 16'h0000, 1'b1, '{1'b0, 16'h0000, 1'b0, 6'd0}},
    '{1'b0, 6'd0,  OP_LOOKUP, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, '{1'b0, 16'h0000, 1'b0, 6'd0}},
    // two usable entries: free slot, then lru eviction, hit refreshes the stamp
    '{1'b1, 6'd2,  OP_FILL,   16'h0001, 16'h0010, 16'h00A1, 1'b0, '0},
    '{1'b0, 6'd0,  OP_FILL,   16'h0001, 16'h0011, 16'h00A2, 1'b0, '0},
    '{1'b0, 6'd0,  OP_LOOKUP, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
    '{1'b0, 6'd0,  OP_LOOKUP, 16'h0001, 16'h0010, 16'h0000, 1'b0, '0},
    '{1'b0, 6'd0,  OP_FILL,   16'h0001, 16'h0012, 16'h00A3, 1'b0, '0},
    // disabled: lookups miss, fills dropped, flush still works
    '{1'b1, 6'd0,  OP_LOOKUP, 16'h0001, 16'h0010, 16'h0000, 1'b1, '{1'b0, 16'h0000, 1'b0, 6'd0}},
    '{1'b1, 6'd0,  OP_FILL,   16'h0002, 16'h0020, 16'h0BAD, 1'b1, '{1'b0, 16'h0000, 1'b0, 6'd0}},
    '{1'b0, 6'd0,  OP_FLUSH,  16'h0001, 16'h0000, 16'h0000, 1'b0, '0},
    // oversize count saturates, then the count drops below the valid entries
    '{1'b1, 6'd63, OP_FILL,   16'h0003, 16'h0030, 16'h0033, 1'b0, '0},
    '{1'b0, 6'd0,  OP_FILL,   16'h0003, 16'h0031, 16'h0034, 1'b0, '0},
    '{1'b0, 6'd0,  OP_LOOKUP, 16'h0003, 16'h0030, 16'h0000, 1'b0, '0},
    '{1'b1, 6'd1,  OP_FILL,   16'h0004, 16'h0040, 16'h0044, 1'b0, '0},
    '{1'b0, 6'd0,  OP_LOOKUP, 16'h0003, 16'h0030, 16'h0000, 1'b0, '0},
    '{1'b0, 6'd0,  OP_FLUSH,  16'h0003, 16'h0000, 16'h0000, 1'b0, '0}
  };

  // random phases: usable count, phase length, whether the phase ends in flushes
  logic [CFG_W-1:0] phase_cfg   [12] = '{6'd63, 6'd16, 6'd0, 6'd32, 6'd31, 6'd2,
                                         6'd33, 6'd1, 6'd5, 6'd3, 6'd0, 6'd32};
  int               phase_len   [12] = '{160, 160, 40, 170, 160, 160,
                                         160, 160, 160, 160, 160, 160};
  bit               phase_flush [12] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
                                         1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  // result monitor: compare every result beat against the oldest owed translation
  tlbl_out_t want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_answers.size() == 0) begin
        $display("%0t: result beat with nothing owed, got %p", $time, out_data_o);
        errors++;
      end else begin
        want = owed_answers.pop_front();
        if (out_data_o.hit !== want.hit) begin
          $display("%0t: hit expected %0d got %0d", $time, want.hit, out_data_o.hit);
          errors++;
        end
        if (out_data_o.frame !== want.frame) begin
          $display("%0t: frame expected %h got %h", $time, want.frame, out_data_o.frame);
          errors++;
        end
        if (out_data_o.replaced !== want.replaced) begin
          $display("%0t: replaced expected %0d got %0d", $time, want.replaced,
                   out_data_o.replaced);
          errors++;
        end
        if (out_data_o.removed_count !== want.removed_count) begin
          $display("%0t: removed_count expected %0d got %0d", $time, want.removed_count,
                   out_data_o.removed_count);
          errors++;
        end
        answers_ok++;
      end
    end
  end

  // result side back-pressure: ready bursts broken by random stalls
  initial begin : ready_gen
    int n;
    @(posedge rst_ni);
    forever begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
      n = pick_gap();
      repeat (n) begin
        @(posedge clk_i);
        out_ready_i <= 1'b0;
      end
    end
  end

  // main sequence
  initial begin : stim
    tlbl_in_t req;
    int       r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].wr) write_usable(directed_plan[i].cfgv);
      req.opcode     = directed_plan[i].op;
      req.pid        = directed_plan[i].pid;
      req.page       = directed_plan[i].page;
      req.fill_frame = directed_plan[i].frame;
      send_req(req, directed_plan[i].typed, directed_plan[i].ans);
    end

    for (int ph = 0; ph < 12; ph++) begin
      // last-but-one phase picks its count at random
      write_usable(ph == 10 ? CFG_W'($urandom_range(0, 63)) : phase_cfg[ph]);
      calm    = ($urandom_range(0, 3) == 0);
      // one pid over many pages lets the buffer fill up before the closing flush
      pid_cnt = (ph == 3) ? 1 : $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) begin
        r = $urandom_range(0, 9);
        pid_pool[i] = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : PID_W'($urandom);
      end
      page_base = PAGE_W'($urandom);
      page_span = (ph == 3) ? 48 : $urandom_range(2, 48);
      fill_pct  = (ph == 3) ? 60 : $urandom_range(25, 55);
      flush_pct = (ph == 3) ? 0 : $urandom_range(2, 8);
      for (int n = 0; n < phase_len[ph]; n++) send_req(make_req(), 1'b0, '0);
      if (phase_flush[ph]) begin
        for (int i = 0; i < pid_cnt; i++) begin
          req.opcode     = OP_FLUSH;
          req.pid        = pid_pool[i];
          req.page       = PAGE_W'($urandom);
          req.fill_frame = FRAME_W'($urandom);
          send_req(req, 1'b0, '0);
        end
      end
    end

    // drain, then allow one more request time for stray beats
    in_valid_i <= 1'b0;
    while (owed_answers.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("covered %0d requests, %0d results checked", reqs_taken, answers_ok);
    $display("lookup hits %0d, lru evictions %0d, largest flush %0d entries",
             hit_total, evict_total, widest_flush);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin : watchdog
    #10ms;
    $display("timeout with %0d results still owed", owed_answers.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
design/tlbl_pkg.sv
design/tlbl_ram.sv
design/tlbl_ctrl.sv
design/tlbl_datapath.sv
design/tlb_lru_lookup_fill_flush_unit.sv
tb/tb_top.sv
